// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the soil sensor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/sswc_pkg.sv =====
// ----------------------------------------------------------------------------
// sswc_pkg
// Shared types and constants of the soil sensor reply and watering control.
// ----------------------------------------------------------------------------
package sswc_pkg;

  localparam int MAX_FRAME   = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_AUTO_MODE       = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_START_THRESHOLD = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_STOP_THRESHOLD  = 2'd2;

  localparam logic [7:0]  START_THR_RESET = 8'd30;
  localparam logic [7:0]  STOP_THR_RESET  = 8'd60;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] NEG_LIMIT  = 16'd1000;
  localparam logic [15:0] SIGN_BIT   = 16'h8000;
  localparam logic [15:0] MAG_MASK   = 16'h7FFF;
  localparam logic [15:0] RECIP_10   = 16'd52429;
  localparam int          RECIP_SHIFT = 19;

  localparam logic [5:0]  VALUE_HI_POS = 6'd3;
  localparam logic [5:0]  VALUE_LO_POS = 6'd4;
  localparam logic [5:0]  MIN_FRAME    = 6'd5;
  localparam logic [5:0]  COUNT_SAT    = 6'd63;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic       eval;
    logic [7:0] data;
    logic       last;
    logic       humid;
    logic       idle;
  } work_t;

endpackage

// ===== src/sswc_item_if.sv =====
// ----------------------------------------------------------------------------
// sswc_item_if
// Input channel: reply bytes and evaluate requests.
// ----------------------------------------------------------------------------
interface sswc_item_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;
  logic       last_byte;
  logic       reading_kind;
  logic       master_idle;

  modport source (output valid, op, rx_byte, last_byte, reading_kind, master_idle,
                  input ready);
  modport sink   (input valid, op, rx_byte, last_byte, reading_kind, master_idle,
                  output ready);
endinterface

// ===== src/sswc_result_if.sv =====
// ----------------------------------------------------------------------------
// sswc_result_if
// Output channel: one status word per input word.
// ----------------------------------------------------------------------------
interface sswc_result_if;
  logic       valid;
  logic       ready;
  logic       frame_done;
  logic       crc_ok;
  logic [7:0] humidity_int;
  logic [3:0] humidity_frac;
  logic       temp_negative;
  logic [7:0] temp_int;
  logic [3:0] temp_frac;
  logic [1:0] command;
  logic       watering;

  modport source (output valid, frame_done, crc_ok, humidity_int, humidity_frac,
                  temp_negative, temp_int, temp_frac, command, watering,
                  input ready);
  modport sink   (input valid, frame_done, crc_ok, humidity_int, humidity_frac,
                  temp_negative, temp_int, temp_frac, command, watering,
                  output ready);
endinterface

// ===== src/sswc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// sswc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sswc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] addr;
  logic [7:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ===== src/soil_sensor_reply_and_watering_control.sv =====
// ----------------------------------------------------------------------------
// soil_sensor_reply_and_watering_control
// Modbus reply checker with soil reading store and automatic watering control.
//
// item channel: one word per reply byte (op 0) or per evaluate request (op 1).
// cfg channel: writes auto_mode (0), start_threshold (1), stop_threshold (2);
//   always ready; to be written only while no word is in flight, unchecked.
// result channel: exactly one word per item word, in order.
// Path: a taken item passes the input register, the queue slot and the two
//   back stages before its result is valid.
// Throughput: one word per cycle while the result is not stalled; the CRC step,
//   reading store and hysteresis feed the first back stage, scaling the second.
// Stall: a stalled result holds; the first back stage fills and holds, the queue
//   keeps taking words until it fills, then the input register fills and item.ready drops.
// Reset: rst clears the queue, presets the CRC, clears frame state, stored readings,
//   the watering flags, and restores the register defaults.
// ----------------------------------------------------------------------------
module soil_sensor_reply_and_watering_control #(
  parameter int DEPTH = sswc_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  sswc_item_if.sink     item,
  sswc_cfg_if.sink      cfg,
  sswc_result_if.source result
);
  import sswc_pkg::*;

  logic  push_valid;
  logic  push_ready;
  work_t push_word;
  logic  pop_valid;
  logic  pop_ready;
  work_t pop_word;

  sswc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word)
  );

  sswc_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_word   (pop_word)
  );

  sswc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_word  (pop_word),
    .cfg       (cfg),
    .result    (result)
  );

endmodule

// ===== src/sswc_front.sv =====
// ----------------------------------------------------------------------------
// sswc_front
// Input register: accepts words, classifies them and pushes them to the queue.
// ----------------------------------------------------------------------------
module sswc_front (
  input  logic             clk,
  input  logic             rst,
  sswc_item_if.sink        item,
  output logic             push_valid,
  input  logic             push_ready,
  output sswc_pkg::work_t  push_word
);
  import sswc_pkg::*;

  logic  full;
  work_t word;
  work_t classified;

  always_comb begin
    classified.eval = (item.op == OP_EVAL);
    if (item.op == OP_EVAL) begin
      classified.data  = 8'h00;
      classified.last  = 1'b0;
      classified.humid = 1'b0;
      classified.idle  = item.master_idle;
    end else begin
      classified.data  = item.rx_byte;
      classified.last  = item.last_byte;
      classified.humid = item.reading_kind;
      classified.idle  = 1'b0;
    end
  end

  assign item.ready = !full || push_ready;
  assign push_valid = full;
  assign push_word  = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (item.ready) begin
      full <= item.valid;
    end
    if (item.ready && item.valid) begin
      word <= classified;
    end
  end

endmodule

// ===== src/sswc_queue.sv =====
// ----------------------------------------------------------------------------
// sswc_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sswc_queue #(
  parameter int DEPTH = sswc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  sswc_pkg::work_t  push_word,
  output logic             pop_valid,
  input  logic             pop_ready,
  output sswc_pkg::work_t  pop_word
);
  import sswc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  work_t         slots [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_word   = slots[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wptr] <= push_word;
    end
  end

  `ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH))
  `ASSERT_NXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

// ===== src/sswc_back.sv =====
// ----------------------------------------------------------------------------
// sswc_back
// Executes queued words: CRC check, reading store, watering hysteresis,
// then scales stored readings into the registered result word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sswc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  sswc_pkg::work_t  pop_word,
  sswc_cfg_if.sink         cfg,
  sswc_result_if.source    result
);
  import sswc_pkg::*;

  typedef struct packed {
    logic        done;
    logic        ok;
    cmd_t        cmd;
    logic        watering;
    logic [15:0] hum_raw;
    logic [15:0] temp_raw;
  } stage_t;

  localparam logic [6:0] FRAME_LIMIT = 7'(MAX_FRAME);

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [12:0] div10(input logic [15:0] x);
    logic [31:0] p;
    p = {16'h0000, x} * {16'h0000, RECIP_10};
    return p[31:RECIP_SHIFT];
  endfunction

  // configuration
  logic       auto_mode;
  logic [7:0] start_thr;
  logic [7:0] stop_thr;

  // execution state
  logic [15:0] crc,      crc_next;
  logic [5:0]  count,    count_next;
  logic [7:0]  value_hi, value_hi_next;
  logic [7:0]  value_lo, value_lo_next;
  logic [15:0] hum_raw,  hum_raw_next;
  logic [15:0] temp_raw, temp_raw_next;
  logic        watering, watering_next;
  logic        issued,   issued_next;

  logic        done;
  logic        ok;
  cmd_t        cmd;
  logic [15:0] frame_value;
  logic [12:0] hum_q;
  logic [7:0]  hum_int;

  // pipeline
  stage_t      s1;
  logic        s1_valid;
  logic        o_valid;
  logic        out_open;
  logic        s1_move;
  logic        pop_fire;

  // result scaling
  logic [12:0] rh_q;
  logic [15:0] rh_rem;
  logic [15:0] t_mag;
  logic [12:0] rt_q;
  logic [15:0] rt_rem;

  logic       o_frame_done;
  logic       o_crc_ok;
  logic [7:0] o_hum_int;
  logic [3:0] o_hum_frac;
  logic       o_temp_neg;
  logic [7:0] o_temp_int;
  logic [3:0] o_temp_frac;
  cmd_t       o_cmd;
  logic       o_watering;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_mode <= 1'b0;
      start_thr <= START_THR_RESET;
      stop_thr  <= STOP_THR_RESET;
    end else if (cfg.valid) begin
      case (cfg.addr)
        CFG_AUTO_MODE:       auto_mode <= cfg.data[0];
        CFG_START_THRESHOLD: start_thr <= cfg.data;
        CFG_STOP_THRESHOLD:  stop_thr  <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  assign out_open  = !o_valid || result.ready;
  assign s1_move   = s1_valid && out_open;
  assign pop_ready = !s1_valid || s1_move;
  assign pop_fire  = pop_valid && pop_ready;

  assign hum_q   = div10(hum_raw);
  assign hum_int = hum_q[7:0];

  always_comb begin
    crc_next      = crc;
    count_next    = count;
    value_hi_next = value_hi;
    value_lo_next = value_lo;
    hum_raw_next  = hum_raw;
    temp_raw_next = temp_raw;
    watering_next = watering;
    issued_next   = issued;
    done          = 1'b0;
    ok            = 1'b0;
    cmd           = CMD_NONE;
    frame_value   = {value_hi, value_lo};
    if (pop_fire) begin
      if (pop_word.eval == OP_BYTE) begin
        crc_next = crc_byte(crc, pop_word.data);
        if (count == VALUE_HI_POS) begin
          value_hi_next = pop_word.data;
        end else if (count == VALUE_LO_POS) begin
          value_lo_next = pop_word.data;
        end
        if (count != COUNT_SAT) begin
          count_next = count + 6'd1;
        end
        frame_value = {value_hi_next, value_lo_next};
        if (pop_word.last) begin
          done = 1'b1;
          ok   = (crc_next == 16'h0000) && (count_next >= MIN_FRAME) &&
                 ({1'b0, count_next} <= FRAME_LIMIT);
          if (ok) begin
            if (pop_word.humid) begin
              hum_raw_next = frame_value;
            end else if (frame_value > NEG_LIMIT) begin
              temp_raw_next = (~frame_value + 16'd1) | SIGN_BIT;
            end else begin
              temp_raw_next = frame_value;
            end
          end
          crc_next      = CRC_INIT;
          count_next    = '0;
          value_hi_next = '0;
          value_lo_next = '0;
        end
      end else if (auto_mode) begin
        if (hum_int < start_thr) begin
          watering_next = 1'b1;
          if (!issued) begin
            cmd         = CMD_START;
            issued_next = 1'b1;
          end
        end else if (hum_int >= stop_thr && watering) begin
          watering_next = 1'b0;
          issued_next   = 1'b0;
          cmd           = CMD_STOP;
        end
        if (watering_next && pop_word.idle) begin
          issued_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc      <= CRC_INIT;
      count    <= '0;
      value_hi <= '0;
      value_lo <= '0;
      hum_raw  <= '0;
      temp_raw <= '0;
      watering <= 1'b0;
      issued   <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      crc      <= crc_next;
      count    <= count_next;
      value_hi <= value_hi_next;
      value_lo <= value_lo_next;
      hum_raw  <= hum_raw_next;
      temp_raw <= temp_raw_next;
      watering <= watering_next;
      issued   <= issued_next;
      if (pop_ready) begin
        s1_valid <= pop_valid;
      end
    end
    if (pop_fire) begin
      s1.done     <= done;
      s1.ok       <= ok;
      s1.cmd      <= cmd;
      s1.watering <= watering_next;
      s1.hum_raw  <= hum_raw_next;
      s1.temp_raw <= temp_raw_next;
    end
  end

  assign rh_q   = div10(s1.hum_raw);
  assign rh_rem = s1.hum_raw - (16'({rh_q, 3'b000}) + 16'({rh_q, 1'b0}));
  assign t_mag  = s1.temp_raw & MAG_MASK;
  assign rt_q   = div10(t_mag);
  assign rt_rem = t_mag - (16'({rt_q, 3'b000}) + 16'({rt_q, 1'b0}));

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_open) begin
      o_valid <= s1_valid;
    end
    if (s1_move) begin
      o_frame_done <= s1.done;
      o_crc_ok     <= s1.ok;
      o_hum_int    <= rh_q[7:0];
      o_hum_frac   <= rh_rem[3:0];
      o_temp_neg   <= s1.temp_raw[15];
      o_temp_int   <= rt_q[7:0];
      o_temp_frac  <= rt_rem[3:0];
      o_cmd        <= s1.cmd;
      o_watering   <= s1.watering;
    end
  end

  assign result.valid         = o_valid;
  assign result.frame_done    = o_frame_done;
  assign result.crc_ok        = o_crc_ok;
  assign result.humidity_int  = o_hum_int;
  assign result.humidity_frac = o_hum_frac;
  assign result.temp_negative = o_temp_neg;
  assign result.temp_int      = o_temp_int;
  assign result.temp_frac     = o_temp_frac;
  assign result.command       = o_cmd;
  assign result.watering      = o_watering;

  `ASSERT_IMP(a_ok_needs_done, clk, rst, o_valid && o_crc_ok, o_frame_done)
  `ASSERT_IMP(a_cmd_not_on_frame, clk, rst, o_valid && o_cmd != CMD_NONE, !o_frame_done)
  `ASSERT_NXT(a_crc_holds_idle, clk, rst, !pop_fire, crc == $past(crc))

endmodule
